// ===== src/ptw_pkg.sv =====
// Shared types and constants for the page table walker.
package ptw_pkg;

    localparam int VA_W     = 48;
    localparam int PA_W     = 32;
    localparam int LEVELS_W = 3;
    localparam int IN_W     = 88;  // 48 + 3 + 32 = 83 bits, padded to whole bytes
    localparam int IDX_W    = 9;

    localparam int SHIFT_L1 = 39;
    localparam int SHIFT_L2 = 30;
    localparam int SHIFT_L3 = 21;
    localparam int SHIFT_L4 = 12;

    localparam logic [LEVELS_W-1:0] SHORT_WALK_LEVELS = 3'd3;

    typedef enum logic [1:0] {
        ST_READ   = 2'd0,
        ST_DONE   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        WS_IDLE = 3'd0,
        WS_L1   = 3'd1,
        WS_L2   = 3'd2,
        WS_L3   = 3'd3,
        WS_L4   = 3'd4
    } t_walk_step;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_REPLY   = 1'b1
    } t_kind;

    typedef struct packed {
        t_status           status;
        logic [PA_W-1:0]   address;
    } t_result;

    // Entry address: entry masked to 4 KB plus index times 8 (never carries into bit 12)
    function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] entry,
                                                   input logic [IDX_W-1:0] idx);
        entry_addr = {entry[PA_W-1:12], idx, 3'b000};
    endfunction

endpackage

// ===== src/page_table_walker.sv =====
// Top level of the page table walker: stream ports, walk step and result buffer.
// The walk step is a single mask-and-concatenate pass; the result buffer registers
// its result for m_axis. Throughput: one item per cycle while s_axis_tready is high.
// A two-entry result buffer keeps s_axis_tready high while one result stalls.
// Reset (i_rst_n low at a clock edge) clears the walk to idle, table_base to zero,
// and empties the result buffer.
module page_table_walker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ptw_pkg::PA_W-1:0]   i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [47:0] virtual_address, [50:48] walk_levels, [82:51] read_data, [87:83] zero
    input  logic [ptw_pkg::IN_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [31:0] address
    output logic [ptw_pkg::PA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [1:0]                 m_axis_tuser
);
    import ptw_pkg::*;

    logic    w_accept;
    t_result w_result, w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    ptw_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_kind        (s_axis_tuser),
        .i_vaddr       (s_axis_tdata[VA_W-1:0]),
        .i_levels      (s_axis_tdata[VA_W +: LEVELS_W]),
        .i_read_data   (s_axis_tdata[VA_W+LEVELS_W +: PA_W]),
        .o_result      (w_result)
    );

    ptw_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (w_result),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_out.address;
    assign m_axis_tuser = w_out.status;

endmodule

// ===== src/ptw_walk.sv =====
// Walk state machine and per-item translation step.
module ptw_walk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ptw_pkg::PA_W-1:0]     i_cfg_wr_data,
    input  logic                         i_accept,
    input  logic                         i_kind,
    input  logic [ptw_pkg::VA_W-1:0]     i_vaddr,
    input  logic [ptw_pkg::LEVELS_W-1:0] i_levels,
    input  logic [ptw_pkg::PA_W-1:0]     i_read_data,
    output ptw_pkg::t_result             o_result
);
    import ptw_pkg::*;

    t_walk_step      r_step, n_step;
    logic [VA_W-1:0] r_vaddr, n_vaddr;
    logic            r_short, n_short;
    logic [PA_W-1:0] r_table_base;

    // Next state
    always_comb begin
        n_step  = r_step;
        n_vaddr = r_vaddr;
        n_short = r_short;
        if (i_kind == KIND_REQUEST) begin
            if (r_step == WS_IDLE) begin
                n_step  = WS_L1;
                n_vaddr = i_vaddr;
                n_short = (i_levels == SHORT_WALK_LEVELS);
            end
        end else begin
            case (r_step)
                WS_L1:   n_step = WS_L2;
                WS_L2:   n_step = WS_L3;
                WS_L3:   n_step = r_short ? WS_IDLE : WS_L4;
                WS_L4:   n_step = WS_IDLE;
                default: n_step = r_step;
            endcase
        end
    end

    // Result of this item
    always_comb begin
        o_result.status  = ST_REJECT;
        o_result.address = '0;
        if (i_kind == KIND_REQUEST) begin
            if (r_step == WS_IDLE) begin
                o_result.status  = ST_READ;
                o_result.address = entry_addr(r_table_base, i_vaddr[SHIFT_L1 +: IDX_W]);
            end
        end else begin
            case (r_step)
                WS_L1: begin
                    o_result.status  = ST_READ;
                    o_result.address = entry_addr(i_read_data, r_vaddr[SHIFT_L2 +: IDX_W]);
                end
                WS_L2: begin
                    o_result.status  = ST_READ;
                    o_result.address = entry_addr(i_read_data, r_vaddr[SHIFT_L3 +: IDX_W]);
                end
                WS_L3: begin
                    if (r_short) begin
                        o_result.status  = ST_DONE;
                        o_result.address = {i_read_data[PA_W-1:SHIFT_L3],
                                            r_vaddr[SHIFT_L3-1:0]};
                    end else begin
                        o_result.status  = ST_READ;
                        o_result.address = entry_addr(i_read_data,
                                                      r_vaddr[SHIFT_L4 +: IDX_W]);
                    end
                end
                WS_L4: begin
                    o_result.status  = ST_DONE;
                    o_result.address = {i_read_data[PA_W-1:SHIFT_L4],
                                        r_vaddr[SHIFT_L4-1:0]};
                end
                default: begin
                    o_result.status  = ST_REJECT;
                    o_result.address = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= WS_IDLE;
            r_vaddr      <= '0;
            r_short      <= 1'b0;
            r_table_base <= '0;
        end else begin
            if (i_accept) begin
                r_step  <= n_step;
                r_vaddr <= n_vaddr;
                r_short <= n_short;
            end
            if (i_cfg_wr_en) begin
                r_table_base <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== src/ptw_obuf.sv =====
// Result register with a skid stage so input can be taken while output stalls.
module ptw_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ptw_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output ptw_pkg::t_result o_data,
    input  logic             i_ready
);
    import ptw_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    w_out_free;

    assign o_ready    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                // skid valid means no item was accepted this cycle
                r_out_valid  <= r_skid_valid || i_valid;
                r_skid_valid <= 1'b0;
            end else if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!w_out_free && i_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== src/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
module ptw_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [ptw_pkg::PA_W-1:0] m_axis_tdata,
    input logic [1:0]               m_axis_tuser
);
    import ptw_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_REJECT |-> m_axis_tdata == '0)
        else $error("rejected item carries a nonzero address");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("buffer not empty after reset");

    // Ready only drops after an item was taken into a stalled output
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without a stalled result");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
